/* hw/rtl/grd_pkg.sv */
// ----------------------------------------------------------------------------
// grd_pkg: shared types and constants of the resistance distance block
// Item formats, the classified command held in the queue, and sequencer codes.
// ----------------------------------------------------------------------------
package grd_pkg;

	localparam logic [1:0] ACT_MAT_WR  = 2'd0;
	localparam logic [1:0] ACT_EDGE_WR = 2'd1;
	localparam logic [1:0] ACT_QUERY   = 2'd2;

	localparam logic [16:0] ONE_Q16 = 17'd65536;

	// Depth of the queue between the front and the back end.
	localparam int QDEPTH = 4;

	// Width of one edge table entry: start vertex, end vertex, length.
	localparam int EDGE_W = 44;

	// A query is issued in seven steps of up to two terms each.
	localparam int          STEP_W    = 3;
	localparam logic [2:0]  LAST_STEP = 3'd6;

	typedef struct packed {
		logic [1:0]         action;
		logic [5:0]         vertex_a;
		logic [5:0]         vertex_b;
		logic signed [31:0] value;
		logic [6:0]         edge_u;
		logic [16:0]        pos_u;
		logic [6:0]         edge_v;
		logic [16:0]        pos_v;
	} in_item_t;

	typedef struct packed {
		logic signed [47:0] distance;
		logic               saturated;
	} out_item_t;

	typedef enum logic [1:0] {
		CMD_MAT_WR,
		CMD_EDGE_WR,
		CMD_QUERY
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t          kind;
		logic [5:0]         va;
		logic [5:0]         vb;
		logic signed [31:0] value;
		logic [6:0]         eu;
		logic [6:0]         ev;
		logic [16:0]        tu;
		logic [16:0]        tv;
		logic               zero;
		logic               same_edge;
	} cmd_t;

	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} head_t;

	typedef enum logic [1:0] {
		COEF_ZERO,
		COEF_POS1,
		COEF_POS2,
		COEF_NEG2
	} coef_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_LATCH,
		BK_ISSUE
	} bk_state_t;

	typedef struct packed {
		logic valid;
		logic first;
		logic last;
	} ctl_t;

endpackage

/* hw/rtl/grd_ram.sv */
// ----------------------------------------------------------------------------
// grd_ram: generic RAM
// One write port and two read ports, read data registered.
// ----------------------------------------------------------------------------
module grd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_a,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_b,
	output logic [WIDTH-1:0]                           rdata_a,
	output logic [WIDTH-1:0]                           rdata_b
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end
endmodule

/* hw/rtl/grd_front.sv */
// ----------------------------------------------------------------------------
// grd_front: command front end
// Decodes and range-checks each item, clamps positions, queues kept commands.
// ----------------------------------------------------------------------------
module grd_front #(
	parameter int NUM_VERTICES = 64,
	parameter int NUM_EDGES    = 128
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  grd_pkg::in_item_t item,
	output grd_pkg::head_t   head,
	input  logic             pop
);
	import grd_pkg::*;

	localparam int QAW = $clog2(QDEPTH);

	cmd_t           cls;
	logic           keep;
	logic           push;
	logic           va_ok, vb_ok, eu_ok, ev_ok;
	cmd_t           fifo_q [QDEPTH];
	logic [QAW-1:0] wr_ptr_q, rd_ptr_q;
	logic [QAW:0]   count_q;

	always_comb begin
		va_ok = int'(item.vertex_a) < NUM_VERTICES;
		vb_ok = int'(item.vertex_b) < NUM_VERTICES;
		eu_ok = int'(item.edge_u) < NUM_EDGES;
		ev_ok = int'(item.edge_v) < NUM_EDGES;

		cls.va        = item.vertex_a;
		cls.vb        = item.vertex_b;
		cls.value     = item.value;
		cls.eu        = item.edge_u;
		cls.ev        = item.edge_v;
		cls.tu        = (item.pos_u > ONE_Q16) ? ONE_Q16 : item.pos_u;
		cls.tv        = (item.pos_v > ONE_Q16) ? ONE_Q16 : item.pos_v;
		cls.same_edge = item.edge_u == item.edge_v;
		// Out-of-range edges and identical sites give a distance of zero.
		cls.zero      = !eu_ok || !ev_ok || (cls.same_edge && cls.tu == cls.tv);

		unique case (item.action)
			ACT_MAT_WR: begin
				cls.kind = CMD_MAT_WR;
				keep     = va_ok && vb_ok;
			end
			ACT_EDGE_WR: begin
				cls.kind = CMD_EDGE_WR;
				keep     = va_ok && vb_ok && eu_ok;
			end
			ACT_QUERY: begin
				cls.kind = CMD_QUERY;
				keep     = 1'b1;
			end
			default: begin
				cls.kind = CMD_QUERY;
				keep     = 1'b0;
			end
		endcase
	end

	assign busy = count_q == (QAW+1)'(QDEPTH);
	assign push = start && !busy && keep;

	assign head.valid = count_q != '0;
	assign head.cmd   = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head.valid) else $error("queue popped while empty");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (QAW+1)'(QDEPTH)) else $error("queue count beyond depth");
	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> count_q == $past(count_q) + 1'b1)
		else $error("queue count did not follow a push");
endmodule

/* hw/rtl/grd_back.sv */
// ----------------------------------------------------------------------------
// grd_back: execution back end
// Performs table writes and runs queries through a two-lane term pipeline.
// ----------------------------------------------------------------------------
module grd_back #(
	parameter int NUM_VERTICES = 64,
	parameter int NUM_EDGES    = 128
) (
	input  logic               clk,
	input  logic               arst_n,
	input  grd_pkg::head_t     head,
	output logic               pop,
	output logic               done,
	output grd_pkg::out_item_t result
);
	import grd_pkg::*;

	localparam int MAW = $clog2(NUM_VERTICES * NUM_VERTICES);
	localparam int EAW = (NUM_EDGES > 1) ? $clog2(NUM_EDGES) : 1;

	typedef struct packed {
		logic [32:0]        w;
		logic               use_len;
		logic signed [31:0] len;
		coef_t              coef;
	} lane_s1_t;

	typedef struct packed {
		logic signed [65:0] prod;
		coef_t              coef;
	} lane_s2_t;

	function automatic logic [MAW-1:0] maddr(logic [5:0] r, logic [5:0] c);
		maddr = MAW'(r) * MAW'(NUM_VERTICES) + MAW'(c);
	endfunction

	bk_state_t   state_q, state_d;
	logic [STEP_W-1:0] step_q;
	cmd_t        cur_q;
	logic        mat_we, edge_we;

	logic [5:0]          aj_q, bj_q, ai_q, bi_q;
	logic signed [31:0]  lj_q, li_q;
	logic [EDGE_W-1:0]   edge_rd_a, edge_rd_b;
	logic [31:0]         mat_rd [2];
	logic [MAW-1:0]      mat_ra [2];

	logic [5:0]          r [2];
	logic [5:0]          c [2];
	logic [16:0]         fa [2];
	logic [16:0]         fb [2];
	coef_t               cf [2];
	logic                ul [2];
	logic signed [31:0]  ln [2];
	logic                sel_min;
	logic [16:0]         au, bu, av, bv;
	logic [33:0]         m1, m2;
	logic [33:0]         pw [2];

	ctl_t                ctl_s1, ctl_s2, ctl_s3;
	lane_s1_t            lane_s1 [2];
	lane_s2_t            lane_s2 [2];
	logic signed [35:0]  term_s3 [2];
	logic signed [39:0]  acc_q, acc_nxt;

	// Sequencer: next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE: begin
				if (head.valid && head.cmd.kind == CMD_QUERY) begin
					state_d = BK_LATCH;
				end
			end
			BK_LATCH: state_d = BK_ISSUE;
			BK_ISSUE: begin
				if (step_q == LAST_STEP) begin
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	// Sequencer: outputs.
	always_comb begin
		pop     = (state_q == BK_IDLE) && head.valid;
		mat_we  = pop && head.cmd.kind == CMD_MAT_WR;
		edge_we = pop && head.cmd.kind == CMD_EDGE_WR;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == BK_ISSUE) begin
				step_q <= step_q + 1'b1;
			end else begin
				step_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= head.cmd;
		end
		if (state_q == BK_LATCH) begin
			aj_q <= edge_rd_a[43:38];
			bj_q <= edge_rd_a[37:32];
			lj_q <= edge_rd_a[31:0];
			ai_q <= edge_rd_b[43:38];
			bi_q <= edge_rd_b[37:32];
			li_q <= edge_rd_b[31:0];
		end
	end

	grd_ram #(.WIDTH(EDGE_W), .DEPTH(NUM_EDGES)) u_edge_ram (
		.clk     (clk),
		.we      (edge_we),
		.waddr   (EAW'(head.cmd.eu)),
		.wdata   ({head.cmd.va, head.cmd.vb, head.cmd.value}),
		.raddr_a (EAW'(head.cmd.eu)),
		.raddr_b (EAW'(head.cmd.ev)),
		.rdata_a (edge_rd_a),
		.rdata_b (edge_rd_b)
	);

	grd_ram #(.WIDTH(32), .DEPTH(NUM_VERTICES * NUM_VERTICES)) u_mat_ram (
		.clk     (clk),
		.we      (mat_we),
		.waddr   (maddr(head.cmd.va, head.cmd.vb)),
		.wdata   (head.cmd.value),
		.raddr_a (mat_ra[0]),
		.raddr_b (mat_ra[1]),
		.rdata_a (mat_rd[0]),
		.rdata_b (mat_rd[1])
	);

	// Term schedule: up to two terms per step, each a matrix entry or an edge length.
	always_comb begin
		au = ONE_Q16 - cur_q.tu;
		bu = cur_q.tu;
		av = ONE_Q16 - cur_q.tv;
		bv = cur_q.tv;
		m1 = bu * av;
		m2 = bv * au;
		sel_min = 1'b0;
		for (int l = 0; l < 2; l++) begin
			r[l]  = '0;
			c[l]  = '0;
			fa[l] = '0;
			fb[l] = '0;
			cf[l] = COEF_ZERO;
			ul[l] = 1'b0;
			ln[l] = '0;
		end
		unique case (step_q)
			3'd0: begin
				r[0] = aj_q; c[0] = aj_q; fa[0] = au; fb[0] = au; cf[0] = COEF_POS1;
				r[1] = bj_q; c[1] = bj_q; fa[1] = bu; fb[1] = bu; cf[1] = COEF_POS1;
			end
			3'd1: begin
				r[0] = aj_q; c[0] = bj_q; fa[0] = au; fb[0] = bu; cf[0] = COEF_POS2;
				r[1] = ai_q; c[1] = ai_q; fa[1] = av; fb[1] = av; cf[1] = COEF_POS1;
			end
			3'd2: begin
				r[0] = bi_q; c[0] = bi_q; fa[0] = bv; fb[0] = bv; cf[0] = COEF_POS1;
				r[1] = ai_q; c[1] = bi_q; fa[1] = av; fb[1] = bv; cf[1] = COEF_POS2;
			end
			3'd3: begin
				r[0] = aj_q; c[0] = ai_q; fa[0] = au; fb[0] = av; cf[0] = COEF_NEG2;
				r[1] = aj_q; c[1] = bi_q; fa[1] = au; fb[1] = bv; cf[1] = COEF_NEG2;
			end
			3'd4: begin
				r[0] = bj_q; c[0] = ai_q; fa[0] = bu; fb[0] = av; cf[0] = COEF_NEG2;
				r[1] = bj_q; c[1] = bi_q; fa[1] = bu; fb[1] = bv; cf[1] = COEF_NEG2;
			end
			3'd5: begin
				ul[0] = 1'b1; ln[0] = li_q; fa[0] = bv; fb[0] = av; cf[0] = COEF_POS1;
				ul[1] = 1'b1; ln[1] = lj_q; fa[1] = bu; fb[1] = au; cf[1] = COEF_POS1;
			end
			3'd6: begin
				// Same-edge correction: the smaller cross weight on the second length.
				ul[0]   = 1'b1;
				ln[0]   = li_q;
				sel_min = 1'b1;
				cf[0]   = cur_q.same_edge ? COEF_NEG2 : COEF_ZERO;
			end
			default: begin
			end
		endcase
		for (int l = 0; l < 2; l++) begin
			if (cur_q.zero) begin
				cf[l] = COEF_ZERO;
			end
			pw[l]     = fa[l] * fb[l];
			mat_ra[l] = maddr(r[l], c[l]);
		end
		if (sel_min) begin
			pw[0] = (m1 < m2) ? m1 : m2;
		end
	end

	// Stage 1: weights, alongside the matrix read.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			done   <= 1'b0;
		end else begin
			ctl_s1.valid <= state_q == BK_ISSUE;
			ctl_s1.first <= step_q == '0;
			ctl_s1.last  <= step_q == LAST_STEP;
			ctl_s2       <= ctl_s1;
			ctl_s3       <= ctl_s2;
			done         <= ctl_s3.valid && ctl_s3.last;
		end
	end

	always_ff @(posedge clk) begin
		for (int l = 0; l < 2; l++) begin
			lane_s1[l].w       <= pw[l][32:0];
			lane_s1[l].use_len <= ul[l];
			lane_s1[l].len     <= ln[l];
			lane_s1[l].coef    <= cf[l];
		end
	end

	// Stage 2: weight times operand, exact.
	always_ff @(posedge clk) begin
		for (int l = 0; l < 2; l++) begin
			lane_s2[l].prod <= $signed({1'b0, lane_s1[l].w}) *
				(lane_s1[l].use_len ? lane_s1[l].len : $signed(mat_rd[l]));
			lane_s2[l].coef <= lane_s1[l].coef;
		end
	end

	// Stage 3: round half up to Q16.16, then apply the term's factor.
	always_ff @(posedge clk) begin
		for (int l = 0; l < 2; l++) begin
			logic signed [65:0] biased;
			logic signed [33:0] rnd;
			biased = lane_s2[l].prod + 66'sd2147483648;
			rnd    = biased[65:32];
			unique case (lane_s2[l].coef)
				COEF_ZERO: term_s3[l] <= '0;
				COEF_POS1: term_s3[l] <= 36'(rnd);
				COEF_POS2: term_s3[l] <= 36'(rnd) <<< 1;
				COEF_NEG2: term_s3[l] <= -(36'(rnd) <<< 1);
				default:   term_s3[l] <= '0;
			endcase
		end
	end

	// Accumulation. Thirteen terms of at most 2^34 in magnitude stay far
	// inside the 40-bit accumulator, so the result never clips.
	always_comb begin
		acc_nxt = (ctl_s3.first ? 40'sd0 : acc_q) + 40'(term_s3[0]) + 40'(term_s3[1]);
	end

	always_ff @(posedge clk) begin
		if (ctl_s3.valid) begin
			acc_q <= acc_nxt;
		end
		if (ctl_s3.valid && ctl_s3.last) begin
			result.distance  <= 48'(acc_nxt);
			result.saturated <= 1'b0;
		end
	end

	a_done_follows_last: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_s3.valid && ctl_s3.last |=> done) else $error("result strobe missing");
	a_step_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == BK_ISSUE |-> step_q <= LAST_STEP) else $error("step overrun");
	a_steps_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_s1.valid && !ctl_s1.first |-> $past(ctl_s1.valid))
		else $error("query steps not contiguous");
	a_no_write_in_query: assert property (@(posedge clk) disable iff (!arst_n)
		mat_we || edge_we |-> state_q == BK_IDLE) else $error("write during query");
endmodule

/* hw/rtl/graph_resistance_distance_top.sv */
// ----------------------------------------------------------------------------
// graph_resistance_distance_top: resistance distance on a metric graph
// Holds the inverse Laplacian and the edge table, answers distance queries.
// ----------------------------------------------------------------------------
// An item transfers at a rising edge with start high and busy low. Matrix and
// edge writes are applied when popped. A query occupies the back end to
// pop it and read both edge entries, to latch them and for seven issue steps;
// the first five read two inverse-Laplacian entries each through the two read
// ports of the matrix memory, the last two use edge lengths. The result
// appears on result with done high for exactly one cycle, once the last issue
// step has passed through the pipeline. There is no way to hold a result
// back, so it must be taken in the cycle done is high. A four-entry queue
// between the front and back end lets start be taken while a query is in
// progress; busy is high only while that queue is full. Results come out in
// the order queries were accepted, and writes are applied in order with them.
module graph_resistance_distance_top #(
	parameter int NUM_VERTICES = 64,
	parameter int NUM_EDGES    = 128
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  grd_pkg::in_item_t  item,
	output logic               done,
	output grd_pkg::out_item_t result
);
	import grd_pkg::*;

	head_t head;
	logic  pop;

	// The front end decodes, checks ranges and queues commands.
	grd_front #(.NUM_VERTICES(NUM_VERTICES), .NUM_EDGES(NUM_EDGES)) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.item   (item),
		.head   (head),
		.pop    (pop)
	);

	// The back end owns both memories and the arithmetic pipeline.
	grd_back #(.NUM_VERTICES(NUM_VERTICES), .NUM_EDGES(NUM_EDGES)) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.pop    (pop),
		.done   (done),
		.result (result)
	);
endmodule
